// File: rtl/core/imh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and codes of the indexed min-heap core.
// ----------------------------------------------------------------------------
package imh_pkg;

	localparam int CAPACITY_DEF    = 1024;
	localparam int ID_BITS_DEF     = 16;
	localparam int WEIGHT_BITS_DEF = 64;

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_DEC   = 2'd1;
	localparam logic [1:0] ACT_POP   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_NOTLOW  = 3'd4;
	localparam logic [2:0] ST_PRESENT = 3'd5;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] node_id;
		logic [63:0] weight;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] top_id;
		logic [63:0] top_weight;
		logic [10:0] entry_count;
		logic        is_empty;
	} out_item_t;

endpackage
`default_nettype wire

// File: rtl/core/imh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: rtl/core/indexed_min_heap_decrease_key_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_core
// Indexed binary min-heap with push, decrease key, pop minimum and clear.
// ----------------------------------------------------------------------------
// Throughput: one item at a time, next taken after the result is accepted;
// each sift level is a read, compare and swap on the single-port heap RAM.
// Reset: arst_n clears control state and the count; RAMs are not cleared,
// presence is checked against the count and the slot's stored id.
module indexed_min_heap_decrease_key_core #(
	parameter int CAPACITY    = imh_pkg::CAPACITY_DEF,
	parameter int ID_BITS     = imh_pkg::ID_BITS_DEF,
	parameter int WEIGHT_BITS = imh_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire imh_pkg::in_item_t  in_data,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output imh_pkg::out_item_t   out_data,
	output logic                 out_valid,
	input  wire logic            out_ready
);
	localparam int SB = $clog2(CAPACITY);   // slot index bits
	localparam int CB = $clog2(CAPACITY + 1); // count bits
	localparam int HW = ID_BITS + WEIGHT_BITS;

	// states
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_FP    = 5'd1;  // position read issued
	localparam logic [4:0] S_FS    = 5'd2;  // slot read issued
	localparam logic [4:0] S_FCHK  = 5'd3;  // presence check
	localparam logic [4:0] S_UPRD  = 5'd4;  // read parent
	localparam logic [4:0] S_UPCMP = 5'd5;  // compare with parent
	localparam logic [4:0] S_UPW2  = 5'd6;  // write displaced parent into child slot
	localparam logic [4:0] S_PLRD  = 5'd7;  // pop: read last
	localparam logic [4:0] S_PLWT  = 5'd8;
	localparam logic [4:0] S_PRRD  = 5'd9;  // pop: read root
	localparam logic [4:0] S_PRWT  = 5'd10;
	localparam logic [4:0] S_DNL   = 5'd11; // read left child
	localparam logic [4:0] S_DNR   = 5'd12; // read right child
	localparam logic [4:0] S_DNRW  = 5'd13;
	localparam logic [4:0] S_DNCMP = 5'd14;
	localparam logic [4:0] S_DNW2  = 5'd15;
	localparam logic [4:0] S_TOP   = 5'd16; // read root for output
	localparam logic [4:0] S_TOPW  = 5'd17;
	localparam logic [4:0] S_OUT   = 5'd18;
	localparam logic [4:0] S_PW    = 5'd19; // write position of moved entry
	localparam logic [4:0] S_PW2   = 5'd20;
	localparam logic [4:0] S_PUSHW = 5'd21;

	import imh_pkg::*;

	logic [4:0] state_q;
	logic [4:0] ret_q;        // state after position write(s)
	logic [CB-1:0] count_q;
	logic [1:0] act_q;
	logic [ID_BITS-1:0] id_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [SB-1:0] at_q;       // current slot of the moving entry
	logic [SB-1:0] oth_q;      // slot it swaps with
	logic [HW-1:0] cur_q;      // moving entry {id, weight}
	logic [HW-1:0] oth_e_q;    // other entry
	logic [HW-1:0] lc_q;
	logic [SB-1:0] p_q;
	logic [2:0] status_q;
	out_item_t out_q;
	logic out_v_q;

	// heap RAM
	logic h_we;
	logic [SB-1:0] h_addr;
	logic [HW-1:0] h_wd, h_rd;
	// position RAM
	logic p_we;
	logic [ID_BITS-1:0] p_addr;
	logic [SB-1:0] p_wd, p_rd;

	imh_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
	imh_ram #(.WIDTH(SB), .DEPTH(2 ** ID_BITS)) u_pos (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));

	wire [ID_BITS-1:0]     rd_id = h_rd[HW-1 -: ID_BITS];
	wire [WEIGHT_BITS-1:0] rd_w  = h_rd[WEIGHT_BITS-1:0];
	wire [WEIGHT_BITS-1:0] cur_w = cur_q[WEIGHT_BITS-1:0];
	wire [WEIGHT_BITS-1:0] lc_w  = lc_q[WEIGHT_BITS-1:0];
	wire [SB-1:0] parent = (at_q - SB'(1)) >> 1;
	wire [SB:0]   left   = {at_q, 1'b1};
	wire [SB:0]   right  = {at_q, 1'b1} + (SB + 1)'(1);
	wire [SB:0]   count_x = (SB + 1)'(count_q);

	assign in_ready  = (state_q == S_IDLE) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// memory port control
	always_comb begin
		h_we = 1'b0; h_addr = at_q; h_wd = cur_q;
		p_we = 1'b0; p_addr = id_q; p_wd = at_q;
		unique case (state_q)
			S_FS:    h_addr = p_rd;
			S_UPRD:  h_addr = parent;
			S_UPCMP: begin
				// swap: moving entry to parent slot
				if (cur_w < rd_w) begin
					h_we = 1'b1; h_addr = parent; h_wd = cur_q;
				end
			end
			S_UPW2, S_DNW2: begin
				h_we = 1'b1; h_addr = oth_q; h_wd = oth_e_q;
			end
			S_PUSHW: begin
				h_we = 1'b1; h_addr = at_q; h_wd = cur_q;
			end
			S_PLRD:  h_addr = SB'(count_q - CB'(1));
			S_PRRD:  h_addr = '0;
			S_PRWT:  begin
				h_we = 1'b1; h_addr = SB'(count_q - CB'(1)); h_wd = h_rd;
			end
			S_DNL:   h_addr = left[SB-1:0];
			S_DNR:   h_addr = right[SB-1:0];
			S_DNCMP: begin
				if (!(cur_w < oth_e_q[WEIGHT_BITS-1:0])) begin
					h_we = 1'b1; h_addr = oth_q; h_wd = cur_q;
				end
			end
			S_PW: begin
				p_we = 1'b1; p_addr = cur_q[HW-1 -: ID_BITS]; p_wd = at_q;
			end
			S_PW2: begin
				p_we = 1'b1; p_addr = oth_e_q[HW-1 -: ID_BITS]; p_wd = oth_q;
			end
			S_TOP:   h_addr = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						act_q    <= in_data.action;
						id_q     <= ID_BITS'(in_data.node_id);
						w_q      <= WEIGHT_BITS'(in_data.weight);
						status_q <= ST_OK;
						priority case (in_data.action)
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= S_TOP;
							end
							ACT_POP: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_TOP;
								end else begin
									state_q <= S_PLRD;
								end
							end
							default: state_q <= S_FP;
						endcase
					end
				end
				S_FP: state_q <= S_FS;
				S_FS: begin
					p_q     <= p_rd;
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					// present when slot < count and slot holds the id
					if ((CB'(p_q) < count_q) && (rd_id == id_q)) begin
						if (act_q == ACT_PUSH) begin
							status_q <= ST_PRESENT;
							state_q  <= S_TOP;
						end else if (!(w_q < rd_w)) begin
							status_q <= ST_NOTLOW;
							state_q  <= S_TOP;
						end else begin
							at_q    <= p_q;
							oth_q   <= p_q;
							cur_q   <= {id_q, w_q};
							ret_q   <= S_UPRD;
							state_q <= S_PUSHW;
						end
					end else if (act_q != ACT_PUSH) begin
						status_q <= ST_ABSENT;
						state_q  <= S_TOP;
					end else if (count_q >= CB'(CAPACITY)) begin
						status_q <= ST_FULL;
						state_q  <= S_TOP;
					end else begin
						at_q    <= SB'(count_q);
						oth_q   <= SB'(count_q);
						cur_q   <= {id_q, w_q};
						count_q <= count_q + CB'(1);
						ret_q   <= S_UPRD;
						state_q <= S_PUSHW;
					end
				end
				S_PUSHW: state_q <= S_PW;
				S_UPRD: begin
					if (at_q == '0) state_q <= S_TOP;
					else state_q <= S_UPCMP;
				end
				S_UPCMP: begin
					if (cur_w < rd_w) begin
						oth_q   <= at_q;
						oth_e_q <= h_rd;
						at_q    <= parent;
						ret_q   <= S_UPRD;
						state_q <= S_UPW2;
					end else begin
						state_q <= S_TOP;
					end
				end
				S_UPW2, S_DNW2: state_q <= S_PW;
				S_PW: state_q <= (ret_q == S_UPRD || ret_q == S_DNL) &&
				                 (state_q == S_PW) && (oth_q != at_q) ? S_PW2 : ret_q;
				S_PW2: state_q <= ret_q;
				S_PLRD: state_q <= S_PLWT;
				S_PLWT: begin
					cur_q   <= h_rd;
					state_q <= S_PRRD;
				end
				S_PRRD: state_q <= S_PRWT;
				S_PRWT: begin
					// old root stored at last slot; last entry sifts from root
					count_q <= count_q - CB'(1);
					at_q    <= '0;
					oth_q   <= '0;
					ret_q   <= S_DNL;
					state_q <= S_PW;
				end
				S_DNL: begin
					if (left < count_x) begin
						state_q <= S_DNR;
					end else begin
						// leaf: park the moving entry here
						ret_q   <= S_TOP;
						state_q <= S_PUSHW;
					end
				end
				S_DNR: begin
					lc_q    <= h_rd;
					state_q <= S_DNRW;
				end
				S_DNRW: begin
					if ((right < count_x) && !(lc_w < rd_w)) begin
						oth_q   <= right[SB-1:0];
						oth_e_q <= h_rd;
					end else begin
						oth_q   <= left[SB-1:0];
						oth_e_q <= lc_q;
					end
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (!(cur_w < oth_e_q[WEIGHT_BITS-1:0])) begin
						// cur moves to oth slot; child moves up to at slot
						at_q    <= oth_q;
						oth_q   <= at_q;
						ret_q   <= S_DNL;
						state_q <= S_DNW2;
					end else begin
						ret_q   <= S_TOP;
						state_q <= S_PUSHW;
					end
				end
				S_TOP: state_q <= S_TOPW;
				S_TOPW: begin
					out_q.status      <= status_q;
					out_q.top_id      <= (count_q == '0) ? '0 : 16'(rd_id);
					out_q.top_weight  <= (count_q == '0) ? '0 : 64'(rd_w);
					out_q.entry_count <= 11'(count_q);
					out_q.is_empty    <= (count_q == '0);
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
